### hw/rtl/bfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared types and constants for the breadth-first hop distance core:
// graph size, operation codes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package bfs_pkg;

	// Graph size and derived widths
	localparam int NODE_COUNT = 16;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int HOPS_W     = $clog2(NODE_COUNT);
	localparam int HOP_MAX    = 15;

	// Operation codes carried on opcode
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic [NODE_COUNT-1:0] node_set_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EXPAND,
		ST_DONE
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic write_row;
		logic load_query;
		logic pop_node;
		logic next_level;
		logic set_hit;
		logic set_miss;
		logic publish;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic nodes_in_range;
		logic dst_in_frontier;
		logic frontier_empty;
	} dp_status_t;

endpackage

### hw/rtl/bfs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_datapath
// Adjacency matrix, search frontier, visited marks and level counter.
// Dequeues one frontier node a cycle and merges its adjacency row into the
// next level; holds the result and the output payload register.
// ----------------------------------------------------------------------------
module bfs_datapath
	import bfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  logic [3:0]  row_index,
	input  logic [15:0] row_bits,
	input  logic [3:0]  source_node,
	input  logic [3:0]  target_node,
	output dp_status_t  status,
	output logic [3:0]  hop_distance,
	output logic        reachable
);

	node_set_t           adj_q [NODE_COUNT];
	node_set_t           frontier_q;
	node_set_t           visited_q;
	node_set_t           next_q;
	logic [NODE_W-1:0]   dst_q;
	logic [HOPS_W-1:0]   hops_q;
	logic [3:0]          res_hop_q;
	logic                res_hit_q;
	logic [3:0]          hop_distance_q;
	logic                reachable_q;
	logic [NODE_W-1:0]   pop_idx;
	node_set_t           level_new;
	logic                row_in_range;

	// Pick the lowest node still waiting in the frontier
	always_comb begin
		pop_idx = '0;
		for (int i = NODE_COUNT - 1; i >= 0; i--) begin
			if (frontier_q[i]) begin
				pop_idx = NODE_W'(i);
			end
		end
	end

	assign level_new    = next_q & ~visited_q;
	assign row_in_range = 32'(row_index) < NODE_COUNT;

	assign status.nodes_in_range  = (32'(source_node) < NODE_COUNT) &&
		(32'(target_node) < NODE_COUNT);
	assign status.dst_in_frontier = frontier_q[dst_q];
	assign status.frontier_empty  = (frontier_q == '0);

	// Adjacency rows: cleared by reset, one row written per write transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODE_COUNT; i++) begin
				adj_q[i] <= '0;
			end
		end else if (cmd.write_row && row_in_range) begin
			adj_q[NODE_W'(row_index)] <= NODE_COUNT'(row_bits);
		end
	end

	// Search state: load, dequeue, advance level
	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			frontier_q <= node_set_t'(1) << NODE_W'(source_node);
			visited_q  <= node_set_t'(1) << NODE_W'(source_node);
			next_q     <= '0;
			hops_q     <= '0;
			dst_q      <= NODE_W'(target_node);
		end else if (cmd.pop_node) begin
			frontier_q <= frontier_q & (frontier_q - node_set_t'(1));
			next_q     <= next_q | adj_q[pop_idx];
		end else if (cmd.next_level) begin
			frontier_q <= level_new;
			visited_q  <= visited_q | level_new;
			next_q     <= '0;
			hops_q     <= hops_q + HOPS_W'(1);
		end
	end

	// Hold the answer, saturating the hop count
	always_ff @(posedge clk) begin
		if (cmd.set_hit) begin
			res_hit_q <= 1'b1;
			if (32'(hops_q) > HOP_MAX) begin
				res_hop_q <= 4'(HOP_MAX);
			end else begin
				res_hop_q <= 4'(hops_q);
			end
		end else if (cmd.set_miss) begin
			res_hit_q <= 1'b0;
			res_hop_q <= '0;
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			hop_distance_q <= res_hop_q;
			reachable_q    <= res_hit_q;
		end
	end

	assign hop_distance = hop_distance_q;
	assign reachable    = reachable_q;

endmodule

### hw/rtl/bfs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_ctrl
// Controller for the hop distance search: takes transactions, steps the
// datapath through check, dequeue and level advance, and owns the output
// valid flag.
// ----------------------------------------------------------------------------
module bfs_ctrl
	import bfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       opcode,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (opcode == OP_WRITE) begin
						cmd.write_row = 1'b1;
					end else if (status.nodes_in_range) begin
						cmd.load_query = 1'b1;
						state_d        = ST_CHECK;
					end else begin
						cmd.set_miss = 1'b1;
						state_d      = ST_DONE;
					end
				end
			end
			ST_CHECK: begin
				priority if (status.dst_in_frontier) begin
					cmd.set_hit = 1'b1;
					state_d     = ST_DONE;
				end else if (status.frontier_empty) begin
					cmd.set_miss = 1'b1;
					state_d      = ST_DONE;
				end else begin
					state_d = ST_EXPAND;
				end
			end
			ST_EXPAND: begin
				if (status.frontier_empty) begin
					cmd.next_level = 1'b1;
					state_d        = ST_CHECK;
				end else begin
					cmd.pop_node = 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output valid: set on publish, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hw/rtl/bfs_hop_distance_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_hop_distance_core
// Breadth-first hop distance over a 16-node adjacency bit matrix.
// ----------------------------------------------------------------------------
// A write transaction (opcode 0) stores one adjacency row and gives no
// result. A query (opcode 1) searches level by level from source_node and
// returns the fewest hops to target_node with reachable set, or zero with
// reachable clear when the target cannot be reached or either node is out
// of range. Visited marks and frontier are reloaded by every query whose
// nodes are in range. Such a query is accepted, then per level goes through
// a check, a dequeue of each frontier node and a level advance, then a final
// check and a load of the output register. The worst case is a chain that
// reaches every node one level at a time; its length is set by the
// per-level check and advance steps plus the single adjacency row read per
// dequeued node. Writes are taken while a result waits on the output; a
// finished query waits until the output register is free.
module bfs_hop_distance_core
	import bfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [3:0]  row_index,
	input  logic [15:0] row_bits,
	input  logic [3:0]  source_node,
	input  logic [3:0]  target_node,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  hop_distance,
	output logic        reachable
);

	dp_cmd_t    cmd;
	dp_status_t status;

	bfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	bfs_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.row_index    (row_index),
		.row_bits     (row_bits),
		.source_node  (source_node),
		.target_node  (target_node),
		.status       (status),
		.hop_distance (hop_distance),
		.reachable    (reachable)
	);

`ifndef SYNTHESIS
	// Never overwrite a result that is still stalled on the output
	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid || !out_stall))
		else $error("result published over a stalled result");

	// An unreachable answer carries a zero distance
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !reachable) |-> (hop_distance == 4'd0))
		else $error("unreachable result with non-zero distance");

	// A row write leaves the block ready for the next transaction
	a_write_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && opcode == OP_WRITE) |=> !in_stall)
		else $error("row write did not complete in one cycle");
`endif

endmodule
